>>> rtl/lhw_pkg.sv
// Shared constants, codes and types of the lock hold watchdog.
`default_nettype none

package lhw_pkg;

	// Default number of activity slots.
	localparam int SLOTS_DEFAULT = 1024;

	// Field widths.
	localparam int OP_W      = 3;
	localparam int IDX_W     = 10;
	localparam int CNT_W     = 16;
	localparam int UNCH_W    = 32;
	localparam int TIMEOUT_W = 16;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;

	// Remainder unit step counter.
	localparam int DIV_CNT_W = $clog2(UNCH_W);

	// Request queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Operation codes on the request channel.
	typedef enum logic [OP_W-1:0] {
		OP_GRAB    = 3'd0,
		OP_RELEASE = 3'd1,
		OP_ACQUIRE = 3'd2,
		OP_UNLOCK  = 3'd3,
		OP_CHECK   = 3'd4
	} op_t;

	// Work classes decided by the front.
	typedef enum logic [2:0] {
		KIND_NOP,
		KIND_GRAB,
		KIND_RELEASE,
		KIND_ACQUIRE,
		KIND_UNLOCK,
		KIND_CHECK
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   slot;
	} task_t;

	// One row of the slot table.
	typedef struct packed {
		logic [CNT_W-1:0]  gen;
		logic [CNT_W-1:0]  act;
		logic [CNT_W-1:0]  holds;
		logic [CNT_W-1:0]  seen_gen;
		logic [CNT_W-1:0]  seen_holds;
		logic [UNCH_W-1:0] unch;
	} slot_rec_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_UPDATE,
		BK_SCAN,
		BK_DIVIDE
	} back_state_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	typedef struct packed {
		logic                 start;
		logic [UNCH_W-1:0]    dividend;
		logic [TIMEOUT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/lhw_if.sv
// Request and response channel interfaces of the lock hold watchdog.
`default_nettype none

interface lhw_req_if import lhw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [IDX_W-1:0] slot_index;

	modport source(output valid, output operation, output slot_index, input ready);
	modport sink(input valid, input operation, input slot_index, output ready);
endinterface

interface lhw_rsp_if import lhw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] granted_slot;
	logic             no_free_slot;
	logic             stall_found;

	modport source(output valid, output granted_slot, output no_free_slot,
		output stall_found, input ready);
	modport sink(input valid, input granted_slot, input no_free_slot,
		input stall_found, output ready);
endinterface

`default_nettype wire

>>> rtl/lock_hold_watchdog_top.sv
// Top level of the lock hold watchdog.
//
//   Channel  Direction  Handshake        Payload
//   req      in         valid / ready    operation, slot_index
//   rsp      out        valid / ready    granted_slot, no_free_slot, stall_found
//   cfg      in         cfg_we           cfg_wdata (stall_timeout_checks)
//
// Acquire, unlock and release read their slot, then write it back; ignored requests just answer.
// A grab walks the table from the search hint at one slot per cycle until it finds a free slot
// or has looked at every slot. A check tick walks every slot, pausing in the remainder unit
// for each stalled slot met before the first stall of that tick is flagged.
// After reset the table is cleared slot by slot with req.ready low. Two requests queue
// and one result waits in the output register, so a stalled rsp does not stall req at once.
`default_nettype none

module lock_hold_watchdog_top import lhw_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [TIMEOUT_W-1:0] cfg_wdata,
	lhw_req_if.sink              req,
	lhw_rsp_if.source            rsp
);

	// The user must write the timeout register only while the block is idle; it is not enforced.
	logic [TIMEOUT_W-1:0] stall_timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			stall_timeout_q <= cfg_wdata;
		end
	end

	back_status_t status;
	logic         push_valid;
	logic         push_ready;
	task_t        push_task;
	logic         pop_valid;
	logic         pop_ready;
	task_t        pop_task;
	div_req_t     div_req;
	div_rsp_t     div_rsp;

	// The front end classifies each request; the back end owns the slot table.
	lhw_front #(
		.SLOTS(SLOTS)
	) u_front (
		.req        (req),
		.status     (status),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_task  (push_task)
	);

	lhw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_task  (push_task),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_task   (pop_task)
	);

	lhw_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.timeout    (stall_timeout_q),
		.task_valid (pop_valid),
		.task_pop   (pop_ready),
		.task_in    (pop_task),
		.status     (status),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.rsp        (rsp)
	);

	// Remainder of the unchanged count by the timeout, one bit per cycle.
	lhw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

`default_nettype wire

>>> rtl/lhw_front.sv
// Request front end: accepts requests and classifies them into queue tasks.
`default_nettype none

module lhw_front import lhw_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	lhw_req_if.sink      req,
	input  back_status_t status,
	output logic         push_valid,
	input  logic         push_ready,
	output task_t        push_task
);

	logic  in_range;
	kind_t kind;

	assign in_range = 32'(req.slot_index) < 32'(SLOTS);

	// Unknown codes and out of range release, acquire or unlock become no-ops with an all-zero result.
	always_comb begin
		kind = KIND_NOP;
		unique case (op_t'(req.operation))
			OP_GRAB:    kind = KIND_GRAB;
			OP_RELEASE: kind = in_range ? KIND_RELEASE : KIND_NOP;
			OP_ACQUIRE: kind = in_range ? KIND_ACQUIRE : KIND_NOP;
			OP_UNLOCK:  kind = in_range ? KIND_UNLOCK : KIND_NOP;
			OP_CHECK:   kind = KIND_CHECK;
			default:    kind = KIND_NOP;
		endcase
	end

	assign push_task.kind = kind;
	assign push_task.slot = req.slot_index;
	assign push_valid     = req.valid && !status.clearing;
	assign req.ready      = push_ready && !status.clearing;

endmodule

`default_nettype wire

>>> rtl/lhw_queue.sv
// Short task queue between the front end and the slot engine.
`default_nettype none

module lhw_queue import lhw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  task_t push_task,
	output logic  pop_valid,
	input  logic  pop_ready,
	output task_t pop_task
);

	task_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_task   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_task;
		end
	end

endmodule

`default_nettype wire

>>> rtl/lhw_div.sv
// Bit-serial remainder unit for the stall timeout test.
`default_nettype none

module lhw_div import lhw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [UNCH_W-1:0]    num_q;
	logic [TIMEOUT_W-1:0] den_q;
	logic [TIMEOUT_W-1:0] rem_q;
	logic [TIMEOUT_W:0]   trial;
	logic [TIMEOUT_W:0]   diff;
	logic [TIMEOUT_W-1:0] rem_next;

	// Restoring step: the partial remainder stays below the divisor.
	assign trial    = {rem_q, num_q[UNCH_W-1]};
	assign diff     = trial - {1'b0, den_q};
	assign rem_next = (trial >= {1'b0, den_q}) ? diff[TIMEOUT_W-1:0]
	                                           : trial[TIMEOUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(UNCH_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[UNCH_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.rem_zero = rem_q == '0;

endmodule

`default_nettype wire

>>> rtl/lhw_back.sv
// Slot engine: slot table memory, grab and check walks, result register.
`default_nettype none

module lhw_back import lhw_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [TIMEOUT_W-1:0] timeout,
	input  logic                 task_valid,
	output logic                 task_pop,
	input  task_t                task_in,
	output back_status_t         status,
	output div_req_t             div_req,
	input  div_rsp_t             div_rsp,
	lhw_rsp_if.source            rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] TOP_SLOT = IW'(SLOTS - 1);

	function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] a);
		return (a == TOP_SLOT) ? '0 : a + IW'(1);
	endfunction

	// Slot table.
	slot_rec_t slot_mem_q [SLOTS];
	slot_rec_t rd_data_q;
	logic      rd_en;
	logic      wr_en;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	slot_rec_t wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= slot_mem_q[rd_addr];
		end
	end

	back_state_t      state_q, state_d;
	task_t            task_q, task_d;
	logic [IW-1:0]    dat_addr_q, dat_addr_d;
	logic [IW-1:0]    nxt_addr_q, nxt_addr_d;
	logic [IW-1:0]    steps_q, steps_d;
	logic [IW-1:0]    hint_q, hint_d;
	logic [IW-1:0]    clr_addr_q, clr_addr_d;
	logic             stall_acc_q, stall_acc_d;
	logic             rem_ready_q, rem_ready_d;
	logic             rem_zero_q, rem_zero_d;
	logic             out_valid_q, out_valid_d;
	logic [IDX_W-1:0] out_granted_q, out_granted_d;
	logic             out_nofree_q, out_nofree_d;
	logic             out_stall_q, out_stall_d;

	slot_rec_t cur;
	slot_rec_t upd_rec;
	slot_rec_t grab_rec;
	slot_rec_t chk_rec;
	logic      out_free;
	logic      last;
	logic      stalled;
	logic      need_rem;
	logic      acc_next;

	assign cur      = rd_data_q;
	assign out_free = !out_valid_q || rsp.ready;
	assign last     = steps_q == TOP_SLOT;
	assign stalled  = (cur.gen == cur.seen_gen) && (cur.holds != '0) &&
	                  (cur.holds == cur.seen_holds) && (cur.act == '0);
	assign need_rem = stalled && !stall_acc_q && (timeout != '0);
	// Only used once the remainder for this slot is in hand.
	assign acc_next = stall_acc_q || (need_rem && rem_zero_q);

	always_comb begin
		upd_rec = cur;
		case (task_q.kind)
			KIND_RELEASE: upd_rec.gen = cur.gen + CNT_W'(1);
			KIND_ACQUIRE: begin
				upd_rec.act   = cur.act + CNT_W'(1);
				upd_rec.holds = cur.holds + CNT_W'(1);
			end
			KIND_UNLOCK: begin
				upd_rec.act   = cur.act + CNT_W'(1);
				upd_rec.holds = cur.holds - CNT_W'(1);
			end
			default: upd_rec = cur;
		endcase
	end

	always_comb begin
		grab_rec       = cur;
		grab_rec.gen   = cur.gen + CNT_W'(1);
		grab_rec.act   = '0;
		grab_rec.holds = '0;
	end

	always_comb begin
		chk_rec     = cur;
		chk_rec.act = '0;
		if (stalled) begin
			chk_rec.unch = cur.unch + UNCH_W'(1);
		end else begin
			chk_rec.seen_gen   = cur.gen;
			chk_rec.seen_holds = cur.holds;
			chk_rec.unch       = '0;
		end
	end

	assign div_req.dividend = cur.unch + UNCH_W'(1);
	assign div_req.divisor  = timeout;

	always_comb begin
		state_d       = state_q;
		task_d        = task_q;
		dat_addr_d    = dat_addr_q;
		nxt_addr_d    = nxt_addr_q;
		steps_d       = steps_q;
		hint_d        = hint_q;
		clr_addr_d    = clr_addr_q;
		stall_acc_d   = stall_acc_q;
		rem_ready_d   = rem_ready_q;
		rem_zero_d    = rem_zero_q;
		out_valid_d   = out_valid_q && !rsp.ready;
		out_granted_d = out_granted_q;
		out_nofree_d  = out_nofree_q;
		out_stall_d   = out_stall_q;
		rd_en         = 1'b0;
		rd_addr       = nxt_addr_q;
		wr_en         = 1'b0;
		wr_addr       = dat_addr_q;
		wr_data       = cur;
		task_pop      = 1'b0;
		div_req.start = 1'b0;

		unique case (state_q)
			BK_CLEAR: begin
				wr_en      = 1'b1;
				wr_addr    = clr_addr_q;
				wr_data    = '0;
				clr_addr_d = next_slot(clr_addr_q);
				if (clr_addr_q == TOP_SLOT) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (task_valid) begin
					task_pop = 1'b1;
					task_d   = task_in;
					unique case (task_in.kind)
						KIND_GRAB: begin
							rd_en      = 1'b1;
							rd_addr    = hint_q;
							dat_addr_d = hint_q;
							nxt_addr_d = next_slot(hint_q);
							steps_d    = '0;
							state_d    = BK_SCAN;
						end
						KIND_CHECK: begin
							rd_en       = 1'b1;
							rd_addr     = '0;
							dat_addr_d  = '0;
							nxt_addr_d  = next_slot('0);
							steps_d     = '0;
							stall_acc_d = 1'b0;
							rem_ready_d = 1'b0;
							state_d     = BK_SCAN;
						end
						default: begin
							rd_en      = task_in.kind != KIND_NOP;
							rd_addr    = IW'(task_in.slot);
							dat_addr_d = IW'(task_in.slot);
							state_d    = BK_UPDATE;
						end
					endcase
				end
			end
			BK_UPDATE: begin
				if (out_free) begin
					wr_en         = task_q.kind != KIND_NOP;
					wr_data       = upd_rec;
					out_valid_d   = 1'b1;
					out_granted_d = '0;
					out_nofree_d  = 1'b0;
					out_stall_d   = 1'b0;
					state_d       = BK_IDLE;
				end
			end
			BK_SCAN: begin
				if (task_q.kind == KIND_GRAB) begin
					if (!cur.gen[0] || last) begin
						if (out_free) begin
							wr_en         = !cur.gen[0];
							wr_data       = grab_rec;
							out_valid_d   = 1'b1;
							out_granted_d = !cur.gen[0] ? IDX_W'(dat_addr_q) : '0;
							out_nofree_d  = cur.gen[0];
							out_stall_d   = 1'b0;
							if (!cur.gen[0]) begin
								hint_d = dat_addr_q;
							end
							state_d = BK_IDLE;
						end
					end else begin
						rd_en      = 1'b1;
						dat_addr_d = nxt_addr_q;
						nxt_addr_d = next_slot(nxt_addr_q);
						steps_d    = steps_q + IW'(1);
					end
				end else if (need_rem && !rem_ready_q) begin
					div_req.start = 1'b1;
					state_d       = BK_DIVIDE;
				end else if (last) begin
					if (out_free) begin
						wr_en         = 1'b1;
						wr_data       = chk_rec;
						out_valid_d   = 1'b1;
						out_granted_d = '0;
						out_nofree_d  = 1'b0;
						out_stall_d   = acc_next;
						state_d       = BK_IDLE;
					end
				end else begin
					wr_en       = 1'b1;
					wr_data     = chk_rec;
					stall_acc_d = acc_next;
					rem_ready_d = 1'b0;
					rd_en       = 1'b1;
					dat_addr_d  = nxt_addr_q;
					nxt_addr_d  = next_slot(nxt_addr_q);
					steps_d     = steps_q + IW'(1);
				end
			end
			BK_DIVIDE: begin
				if (div_rsp.done) begin
					rem_ready_d = 1'b1;
					rem_zero_d  = div_rsp.rem_zero;
					state_d     = BK_SCAN;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			hint_q      <= '0;
			clr_addr_q  <= '0;
			stall_acc_q <= 1'b0;
			rem_ready_q <= 1'b0;
			rem_zero_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			hint_q      <= hint_d;
			clr_addr_q  <= clr_addr_d;
			stall_acc_q <= stall_acc_d;
			rem_ready_q <= rem_ready_d;
			rem_zero_q  <= rem_zero_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		task_q        <= task_d;
		dat_addr_q    <= dat_addr_d;
		nxt_addr_q    <= nxt_addr_d;
		steps_q       <= steps_d;
		out_granted_q <= out_granted_d;
		out_nofree_q  <= out_nofree_d;
		out_stall_q   <= out_stall_d;
	end

	assign status.clearing  = state_q == BK_CLEAR;
	assign rsp.valid        = out_valid_q;
	assign rsp.granted_slot = out_granted_q;
	assign rsp.no_free_slot = out_nofree_q;
	assign rsp.stall_found  = out_stall_q;

endmodule

`default_nettype wire

>>> rtl/lhw_checker.sv
// Port-level checks of the lock hold watchdog and their binding to the top level.
`default_nettype none

module lhw_checker import lhw_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [IDX_W-1:0] granted_slot,
	input logic             no_free_slot,
	input logic             stall_found
);

	localparam logic [2:0] MAX_PENDING = 3'd4;

	// Requests taken whose result has not yet been delivered.
	logic [2:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = req_valid && req_ready;
	assign out_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted_slot) &&
		$stable(no_free_slot) && $stable(stall_found))
		else $error("result changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != '0)
		else $error("result without a pending request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= MAX_PENDING)
		else $error("more requests in flight than the buffering holds");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(no_free_slot && stall_found) &&
		(!no_free_slot || granted_slot == '0) &&
		(!stall_found || granted_slot == '0))
		else $error("result fields from different operations");

endmodule

bind lock_hold_watchdog_top lhw_checker u_lhw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.granted_slot (rsp.granted_slot),
	.no_free_slot (rsp.no_free_slot),
	.stall_found  (rsp.stall_found)
);

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the lock hold watchdog top level.
`timescale 1ns / 1ps

module testbench;
	import lhw_pkg::*;

	localparam int SLOTS = SLOTS_DEFAULT;
	// Slots that the random traffic treats as its own sessions.
	localparam int WORK_SET = 12;
	// Far above the slowest legal run, which is dominated by check ticks walking the table.
	localparam int CYCLE_LIMIT = 4000000;
	localparam logic [OP_W-1:0] OP_CODE_MAX = '1;

	// One answer of the block, as the response channel carries it.
	typedef struct packed {
		logic [IDX_W-1:0] granted;
		logic             no_free;
		logic             stall;
	} answer_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [TIMEOUT_W-1:0] cfg_wdata;

	lhw_req_if req_bus ();
	lhw_rsp_if rsp_bus ();

	lock_hold_watchdog_top #(.SLOTS(SLOTS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	// Shadow copy of the slot table. bit types start at zero, which matches the
	// state after reset, and reset is applied only once.
	bit [CNT_W-1:0]     slot_gen   [SLOTS];
	bit [CNT_W-1:0]     slot_act   [SLOTS];
	bit [CNT_W-1:0]     slot_holds [SLOTS];
	bit [CNT_W-1:0]     seen_gen   [SLOTS];
	bit [CNT_W-1:0]     seen_holds [SLOTS];
	bit [UNCH_W-1:0]    unch_count [SLOTS];
	bit [IDX_W-1:0]     search_hint;
	bit [TIMEOUT_W-1:0] stall_timeout = TIMEOUT_RESET;

	// Answers predicted for accepted requests, oldest first.
	answer_t          pending_answers [$];
	answer_t          last_answer;
	logic [IDX_W-1:0] held_slots [$];

	int  error_count = 0;
	int  cycle_count = 0;
	int  burst_left  = 0;
	bit  req_on      = 1'b0;
	int  useful_sent = 0;
	int  grabs_sent  = 0;
	int  checks_sent = 0;
	int  stalls_seen = 0;
	int  refusals    = 0;
	int  settings    = 0;

	// Free-running clock, 4 ns period.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Works out the answer to one request and moves the shadow table on by it.
	// Grabs search round-robin from the hint for an even generation; a check tick
	// counts stalled slots and flags when a count reaches a multiple of the timeout.
	function automatic answer_t predict_answer(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
		answer_t     ans;
		int unsigned slot;
		ans = '0;
		case (op)
			OP_GRAB: begin
				ans.no_free = 1'b1;
				for (int offset = 0; offset < SLOTS && ans.no_free; offset++) begin
					slot = (search_hint + offset) % SLOTS;
					if (!slot_gen[slot][0]) begin
						slot_gen[slot]   = slot_gen[slot] + 1'b1;
						slot_act[slot]   = '0;
						slot_holds[slot] = '0;
						search_hint      = IDX_W'(slot);
						ans.granted      = IDX_W'(slot);
						ans.no_free      = 1'b0;
					end
				end
			end
			OP_RELEASE: begin
				slot_gen[idx] = slot_gen[idx] + 1'b1;
			end
			OP_ACQUIRE: begin
				slot_act[idx]   = slot_act[idx] + 1'b1;
				slot_holds[idx] = slot_holds[idx] + 1'b1;
			end
			OP_UNLOCK: begin
				slot_act[idx]   = slot_act[idx] + 1'b1;
				slot_holds[idx] = slot_holds[idx] - 1'b1;
			end
			OP_CHECK: begin
				for (int s = 0; s < SLOTS; s++) begin
					if (slot_gen[s] == seen_gen[s] && slot_holds[s] != '0 &&
							slot_holds[s] == seen_holds[s] && slot_act[s] == '0) begin
						unch_count[s] = unch_count[s] + 1'b1;
						if (stall_timeout != '0 && unch_count[s] % stall_timeout == '0)
							ans.stall = 1'b1;
					end else begin
						seen_gen[s]   = slot_gen[s];
						seen_holds[s] = slot_holds[s];
						unch_count[s] = '0;
					end
					slot_act[s] = '0;
				end
			end
			default: begin
			end
		endcase
		return ans;
	endfunction

	function automatic int free_slot_count();
		int total;
		total = 0;
		for (int s = 0; s < SLOTS; s++)
			if (!slot_gen[s][0])
				total++;
		return total;
	endfunction

	// Drops valid and scrambles the payload so that idle cycles carry noise.
	task automatic park_request_channel();
		if (req_on) begin
			req_bus.valid      <= 1'b0;
			req_bus.operation  <= OP_W'($urandom);
			req_bus.slot_index <= IDX_W'($urandom);
			req_on = 1'b0;
		end
	endtask

	// Presents one request and returns once it has been accepted. Requests go out
	// in bursts; valid stays high across a burst, and a new burst always starts
	// after an idle gap, so valid is never lowered and raised in one step.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) :
				$urandom_range(1, 12);
			park_request_channel();
			repeat (gap) @(posedge clk);
		end
		req_bus.valid      <= 1'b1;
		req_bus.operation  <= op;
		req_bus.slot_index <= idx;
		req_on = 1'b1;
		do @(posedge clk); while (!req_bus.ready);
		last_answer = predict_answer(op, idx);
		pending_answers.push_back(last_answer);
		burst_left--;
		if (op <= OP_CHECK)
			useful_sent++;
		if (op == OP_GRAB)
			grabs_sent++;
		if (op == OP_CHECK)
			checks_sent++;
	endtask

	// Holds the sender back until every outstanding request has been answered.
	task automatic wait_for_answers();
		park_request_channel();
		burst_left = 0;
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	// Writes the stall timeout register; only called with nothing outstanding.
	task automatic write_stall_timeout(input logic [TIMEOUT_W-1:0] value);
		@(posedge clk);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		stall_timeout = value;
		settings++;
	endtask

	// One random request. Most traffic is well-formed sessions on a small set of
	// grabbed slots; the rest is stray operations on arbitrary slots and spare codes.
	task automatic send_random_request();
		int unsigned      pick;
		int               spot;
		logic [IDX_W-1:0] slot;
		pick = $urandom_range(0, 99);
		if (held_slots.size() == 0 || (pick < 8 && held_slots.size() < WORK_SET)) begin
			send_request(OP_GRAB, IDX_W'($urandom));
			if (!last_answer.no_free)
				held_slots.push_back(last_answer.granted);
		end else if (pick < 45) begin
			send_request(OP_ACQUIRE, held_slots[$urandom_range(0, held_slots.size() - 1)]);
		end else if (pick < 75) begin
			// Prefer a slot that still holds a lock, so hold counts rise and fall.
			spot = $urandom_range(0, held_slots.size() - 1);
			if (slot_holds[held_slots[spot]] == '0)
				spot = $urandom_range(0, held_slots.size() - 1);
			send_request(OP_UNLOCK, held_slots[spot]);
		end else if (pick < 80) begin
			spot = $urandom_range(0, held_slots.size() - 1);
			send_request(OP_RELEASE, held_slots[spot]);
			held_slots.delete(spot);
		end else if (pick < 90) begin
			send_request(OP_CHECK, IDX_W'($urandom));
		end else if (pick < 91) begin
			wait_for_answers();
		end else begin
			slot = ($urandom_range(0, 2) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 31));
			send_request(OP_W'($urandom_range(0, int'(OP_CODE_MAX))), slot);
		end
	endtask

	// Every operation once or more at the reset timeout: grabs that walk past a
	// taken slot, a slot release and regrab, lock events on slots never grabbed,
	// a hold count that wraps below zero, the spare operation codes and check ticks.
	task automatic test_directed_requests();
		send_request(OP_GRAB, '0);
		send_request(OP_GRAB, '1);
		send_request(OP_ACQUIRE, '0);
		send_request(OP_ACQUIRE, '0);
		send_request(OP_UNLOCK, '0);
		send_request(OP_RELEASE, IDX_W'(1));
		send_request(OP_GRAB, IDX_W'(SLOTS - 1));
		send_request(OP_ACQUIRE, IDX_W'(SLOTS - 1));
		send_request(OP_UNLOCK, IDX_W'(SLOTS - 2));
		send_request(OP_RELEASE, IDX_W'(SLOTS - 1));
		for (int code = int'(OP_CHECK) + 1; code <= int'(OP_CODE_MAX); code++)
			send_request(OP_W'(code), (code % 2 != 0) ? 10'h155 : 10'h2AA);
		send_request(OP_CHECK, '0);
		send_request(OP_CHECK, '1);
		send_request(OP_CHECK, 10'h155);
		send_request(OP_UNLOCK, '0);
		send_request(OP_GRAB, 10'h2AA);
		send_request(OP_CHECK, 10'h2AA);
		wait_for_answers();
	endtask

	// Random sessions under a run of timeout settings: the lowest that flags, a few small
	// ones that flag often, zero which never flags, the highest and the default.
	task automatic test_stall_settings();
		logic [TIMEOUT_W-1:0] timeouts [7];
		int                   target;
		timeouts = '{16'd1, 16'd3, 16'd0, 16'd2, 16'hFFFF, TIMEOUT_W'($urandom_range(4, 9)),
			TIMEOUT_RESET};
		foreach (timeouts[k]) begin
			wait_for_answers();
			write_stall_timeout(timeouts[k]);
			target = useful_sent + 30;
			while (useful_sent < target)
				send_random_request();
		end
		wait_for_answers();
	endtask

	// Fills every slot so that a grab is refused, then frees two slots and
	// grabs them back with long walks around the table.
	task automatic test_table_full();
		write_stall_timeout(16'd1);
		while (free_slot_count() != 0)
			send_request(OP_GRAB, IDX_W'($urandom));
		send_request(OP_GRAB, IDX_W'($urandom));
		send_request(OP_ACQUIRE, IDX_W'($urandom));
		send_request(OP_CHECK, '0);
		send_request(OP_CHECK, '0);
		send_request(OP_RELEASE, IDX_W'($urandom));
		send_request(OP_RELEASE, IDX_W'($urandom));
		send_request(OP_GRAB, IDX_W'($urandom));
		send_request(OP_GRAB, IDX_W'($urandom));
		send_request(OP_GRAB, IDX_W'($urandom));
		wait_for_answers();
	endtask

	// The response side stalls on a pattern of its own: long ready stretches,
	// long stalls, and short choppy runs where ready flips almost every cycle.
	initial begin : response_ready_pattern
		int   hold;
		logic level;
		hold  = 0;
		level = 1'b0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				case ($urandom_range(0, 3))
					0: begin
						level = 1'b1;
						hold  = $urandom_range(20, 200);
					end
					1: begin
						level = 1'b0;
						hold  = $urandom_range(1, 40);
					end
					default: begin
						level = $urandom_range(0, 1);
						hold  = $urandom_range(1, 4);
					end
				endcase
			end
			hold--;
			rsp_bus.ready <= level;
		end
	end

	// Each accepted response is matched against the oldest predicted answer.
	always @(posedge clk) begin : answer_checker
		answer_t want;
		if (arst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
			if (pending_answers.size() == 0) begin
				$error("response accepted with no request outstanding");
				error_count++;
			end else begin
				want = pending_answers.pop_front();
				if (rsp_bus.granted_slot !== want.granted) begin
					$error("granted_slot: expected %0d, actual %0d", want.granted,
						rsp_bus.granted_slot);
					error_count++;
				end
				if (rsp_bus.no_free_slot !== want.no_free) begin
					$error("no_free_slot: expected %0d, actual %0d", want.no_free,
						rsp_bus.no_free_slot);
					error_count++;
				end
				if (rsp_bus.stall_found !== want.stall) begin
					$error("stall_found: expected %0d, actual %0d", want.stall,
						rsp_bus.stall_found);
					error_count++;
				end
				if (want.stall)
					stalls_seen++;
				if (want.no_free)
					refusals++;
			end
		end
	end

	// A hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Cycle limit reached with %0d answers outstanding",
				pending_answers.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Main sequence. Reset is held low first; the block then clears its table
	// and keeps req.ready low meanwhile, which the first request simply waits out.
	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		req_bus.valid      <= 1'b0;
		req_bus.operation  <= '0;
		req_bus.slot_index <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_requests();
		test_stall_settings();
		test_table_full();

		// Give the block a little time to show any response it should not send.
		wait_for_answers();
		repeat (64) @(posedge clk);

		$display("Covered %0d requests: %0d grabs, %0d refused on a full table, %0d check ticks",
			useful_sent, grabs_sent, refusals, checks_sent);
		$display("with %0d stalls flagged over %0d timeout settings, zero and both ends included",
			stalls_seen, settings);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
